>>> sv/dipi_pkg.sv
// ----------------------------------------------------------------------------
// dipi_pkg
// Shared types, widths, register indexes and reset values for the
// dual-channel incremental PI speed controller.
// ----------------------------------------------------------------------------
package dipi_pkg;

  localparam int CHANNELS_DEF       = 2;
  localparam int LOW_BATTERY_Q8_DEF = 1280;

  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int LOWER_W    = 16;
  localparam int SPD_W      = 16;
  localparam int VOLT_W     = 12;
  localparam int ERR_W      = SPD_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int ACC_W      = 25;
  localparam int FRAC_W     = 8;
  localparam int PROD_P_W   = GAIN_W + 1 + DIFF_W;
  localparam int PROD_I_W   = GAIN_W + 1 + ERR_W;
  localparam int SUM_W      = 36;
  localparam int DRIVE_W    = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam logic [GAIN_W-1:0]  KP_CHG_RST   = 16'd32000;
  localparam logic [GAIN_W-1:0]  KI_CHG_RST   = 16'd1920;
  localparam logic [GAIN_W-1:0]  KP_NRM_RST   = 16'd29440;
  localparam logic [GAIN_W-1:0]  KI_NRM_RST   = 16'd1536;
  localparam logic [LIM_W-1:0]   UL_LOW_RST   = 15'd9600;
  localparam logic [LIM_W-1:0]   UL_NRM_RST   = 15'd7000;
  localparam logic [LOWER_W-1:0] LOWER_RST    = 16'hDCD8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_KP_CHARGING   = 3'd0,
    REG_KI_CHARGING   = 3'd1,
    REG_KP_NORMAL     = 3'd2,
    REG_KI_NORMAL     = 3'd3,
    REG_UPPER_LOW_BAT = 3'd4,
    REG_UPPER_NORMAL  = 3'd5,
    REG_LOWER_LIMIT   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]         kp_charging;
    logic [GAIN_W-1:0]         ki_charging;
    logic [GAIN_W-1:0]         kp_normal;
    logic [GAIN_W-1:0]         ki_normal;
    logic [LIM_W-1:0]          upper_limit_low_battery;
    logic [LIM_W-1:0]          upper_limit_normal;
    logic signed [LOWER_W-1:0] lower_limit;
  } cfg_t;

endpackage

>>> sv/dipi_cfg.sv
// ----------------------------------------------------------------------------
// dipi_cfg
// Configuration register file: gains and clamp limits, write only.
// ----------------------------------------------------------------------------
module dipi_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dipi_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dipi_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output dipi_pkg::cfg_t                 cfg
);
  import dipi_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_charging             <= KP_CHG_RST;
      cfg.ki_charging             <= KI_CHG_RST;
      cfg.kp_normal               <= KP_NRM_RST;
      cfg.ki_normal               <= KI_NRM_RST;
      cfg.upper_limit_low_battery <= UL_LOW_RST;
      cfg.upper_limit_normal      <= UL_NRM_RST;
      cfg.lower_limit             <= LOWER_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_KP_CHARGING:   cfg.kp_charging             <= cfg_wdata[GAIN_W-1:0];
        REG_KI_CHARGING:   cfg.ki_charging             <= cfg_wdata[GAIN_W-1:0];
        REG_KP_NORMAL:     cfg.kp_normal               <= cfg_wdata[GAIN_W-1:0];
        REG_KI_NORMAL:     cfg.ki_normal               <= cfg_wdata[GAIN_W-1:0];
        REG_UPPER_LOW_BAT: cfg.upper_limit_low_battery <= cfg_wdata[LIM_W-1:0];
        REG_UPPER_NORMAL:  cfg.upper_limit_normal      <= cfg_wdata[LIM_W-1:0];
        REG_LOWER_LIMIT:   cfg.lower_limit             <= $signed(cfg_wdata[LOWER_W-1:0]);
        default: ;
      endcase
    end
  end

endmodule

>>> sv/dipi_core.sv
// ----------------------------------------------------------------------------
// dipi_core
// Per-channel PI state and the single-pass update: error, gain products,
// upper and lower clamp, truncation toward zero.
// ----------------------------------------------------------------------------
module dipi_core #(
  parameter int CHANNELS       = dipi_pkg::CHANNELS_DEF,
  parameter int LOW_BATTERY_Q8 = dipi_pkg::LOW_BATTERY_Q8_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dipi_pkg::cfg_t                      cfg,
  input  logic                                update,
  input  logic                                channel,
  input  logic signed [dipi_pkg::SPD_W-1:0]   target_speed,
  input  logic signed [dipi_pkg::SPD_W-1:0]   measured_speed,
  input  logic                                charging_active,
  input  logic [dipi_pkg::VOLT_W-1:0]         battery_volts_q8,
  output logic signed [dipi_pkg::DRIVE_W-1:0] drive
);
  import dipi_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [VOLT_W-1:0] LOW_BAT = VOLT_W'(LOW_BATTERY_Q8);

  logic signed [ACC_W-1:0]    drive_accumulator [CHANNELS];
  logic signed [ERR_W-1:0]    previous_error    [CHANNELS];

  logic [CH_W-1:0]            idx;
  logic signed [ERR_W-1:0]    err;
  logic signed [DIFF_W-1:0]   diff;
  logic [GAIN_W-1:0]          kp;
  logic [GAIN_W-1:0]          ki;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [SUM_W-1:0]    sum;
  logic [LIM_W-1:0]           upper;
  logic signed [SUM_W-1:0]    upper_q;
  logic signed [SUM_W-1:0]    lower_q;
  logic signed [SUM_W-1:0]    clamp_hi;
  logic signed [SUM_W-1:0]    clamp_lo;
  logic signed [ACC_W-1:0]    acc_next;
  logic signed [ACC_W-FRAC_W-1:0] quot;

  always_comb begin
    idx = (int'(channel) < CHANNELS) ? CH_W'(channel) : CH_W'(CHANNELS - 1);
    err  = ERR_W'(target_speed) - ERR_W'(measured_speed);
    diff = DIFF_W'(err) - DIFF_W'(previous_error[idx]);
    kp = charging_active ? cfg.kp_charging : cfg.kp_normal;
    ki = charging_active ? cfg.ki_charging : cfg.ki_normal;
    prod_p = $signed({1'b0, kp}) * diff;
    prod_i = $signed({1'b0, ki}) * err;
    sum = SUM_W'(drive_accumulator[idx]) + SUM_W'(prod_p) + SUM_W'(prod_i);

    upper   = (battery_volts_q8 <= LOW_BAT) ? cfg.upper_limit_low_battery
                                            : cfg.upper_limit_normal;
    upper_q = SUM_W'($signed({1'b0, upper, {FRAC_W{1'b0}}}));
    lower_q = SUM_W'($signed({cfg.lower_limit, {FRAC_W{1'b0}}}));

    clamp_hi = (sum > upper_q) ? upper_q : sum;
    clamp_lo = (clamp_hi < lower_q) ? lower_q : clamp_hi;
    acc_next = clamp_lo[ACC_W-1:0];

    quot = acc_next[ACC_W-1:FRAC_W];
    if (acc_next[ACC_W-1] && (|acc_next[FRAC_W-1:0])) begin
      quot = quot + (ACC_W-FRAC_W)'(1);
    end
    drive = quot[DRIVE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        drive_accumulator[i] <= '0;
        previous_error[i]    <= '0;
      end
    end else if (update) begin
      drive_accumulator[idx] <= acc_next;
      previous_error[idx]    <= err;
    end
  end

endmodule

>>> sv/dual_incremental_pi_speed_core.sv
// ----------------------------------------------------------------------------
// dual_incremental_pi_speed_core
// Two-channel incremental PI motor speed controller with output clamp.
//
//   channel  dir  tdata (low bit up)                         tuser
//   s_*      in   target_speed[15:0] measured_speed[31:16]   channel
//                 charging_active[32] battery_volts_q8[44:33]
//                 zero[47:45]
//   m_*      out  drive[15:0]                                channel_res
//   cfg_*    in   write enable, register index, write data   -
//
// An accepted item passes one input register, then the PI update into the
// result register. One item per cycle while m_tready is high; the channel
// state read-modify-write fits in the single update stage, so back-to-back
// items on one channel are exact. Reset clears the state of all channels
// and loads default gains and limits. A stalled result holds the update
// stage; one more item is held in the input register before s_tready
// drops.
// ----------------------------------------------------------------------------
module dual_incremental_pi_speed_core #(
  parameter int CHANNELS       = dipi_pkg::CHANNELS_DEF,
  parameter int LOW_BATTERY_Q8 = dipi_pkg::LOW_BATTERY_Q8_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // target_speed, measured_speed, charging_active, battery_volts_q8, pad
  input  logic [dipi_pkg::IN_DATA_W-1:0]   s_tdata,
  // channel
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // drive
  output logic [dipi_pkg::OUT_DATA_W-1:0]  m_tdata,
  // channel_res
  output logic                             m_tuser,
  input  logic                             cfg_we,
  input  logic [dipi_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [dipi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dipi_pkg::*;

  cfg_t                     cfg;
  logic                     s1_valid;
  logic                     s1_channel;
  logic signed [SPD_W-1:0]  s1_target;
  logic signed [SPD_W-1:0]  s1_measured;
  logic                     s1_charging;
  logic [VOLT_W-1:0]        s1_volts;
  logic                     advance;
  logic                     update;
  logic signed [DRIVE_W-1:0] drive;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign update   = s1_valid && advance;

  dipi_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  dipi_core #(
    .CHANNELS      (CHANNELS),
    .LOW_BATTERY_Q8(LOW_BATTERY_Q8)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .update          (update),
    .channel         (s1_channel),
    .target_speed    (s1_target),
    .measured_speed  (s1_measured),
    .charging_active (s1_charging),
    .battery_volts_q8(s1_volts),
    .drive           (drive)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_channel  <= s_tuser;
      s1_target   <= $signed(s_tdata[SPD_W-1:0]);
      s1_measured <= $signed(s_tdata[2*SPD_W-1:SPD_W]);
      s1_charging <= s_tdata[2*SPD_W];
      s1_volts    <= s_tdata[2*SPD_W+VOLT_W:2*SPD_W+1];
    end
    if (update) begin
      m_tdata <= OUT_DATA_W'(drive);
      m_tuser <= s1_channel;
    end
  end

endmodule

>>> sv/dipi_checker.sv
// ----------------------------------------------------------------------------
// dipi_checker
// Port-level checks for the PI speed core, bound to the top level.
// ----------------------------------------------------------------------------
module dipi_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [dipi_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_item_arrives: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##2 m_tvalid)
    else $error("accepted item produced no result");

endmodule

bind dual_incremental_pi_speed_core dipi_checker u_dipi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
